/* sv/ouvs_pkg.sv */
// ----------------------------------------------------------------------------
// ouvs_pkg: shared types and constants for the ordered unique value set
// Item and result structs, action codes, controller states, command bundle.
// ----------------------------------------------------------------------------
package ouvs_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 32;
	localparam int ACTION_W     = 2;
	localparam int POS_W        = 4;
	localparam int COUNT_W      = 5;

	// action codes; the unused code behaves as a look up
	localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DEL  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FIND = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic signed [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic               was_present;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] count;
		logic               overflow;
	} out_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic update;
	} cmd_t;

endpackage

/* sv/ouvs_ctrl.sv */
// ----------------------------------------------------------------------------
// ouvs_ctrl: controller for the ordered unique value set
// Two-state sequencer: accept an item and search, then apply the update.
// ----------------------------------------------------------------------------
module ouvs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output ouvs_pkg::cmd_t   cmd
);

	ouvs_pkg::state_t state_q;
	ouvs_pkg::state_t state_nxt;
	logic             done_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ouvs_pkg::ST_IDLE: begin
				if (start) state_nxt = ouvs_pkg::ST_UPDATE;
			end
			ouvs_pkg::ST_UPDATE: begin
				state_nxt = ouvs_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ouvs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy       = 1'b0;
		cmd.load   = 1'b0;
		cmd.update = 1'b0;
		case (state_q)
			ouvs_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			ouvs_pkg::ST_UPDATE: begin
				busy       = 1'b1;
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// hold state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ouvs_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.update;
		end
	end

	assign done = done_q;

`ifndef SYNTH
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not enter update");
	a_update_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> done)
		else $error("update not followed by result strobe");
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");
`endif

endmodule

/* sv/ouvs_dp.sv */
// ----------------------------------------------------------------------------
// ouvs_dp: datapath for the ordered unique value set
// Row of value cells with parallel compare, append, shift-down delete.
// ----------------------------------------------------------------------------
module ouvs_dp #(
	parameter int CAPACITY = ouvs_pkg::DEF_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ouvs_pkg::cmd_t cmd,
	input  ouvs_pkg::in_t  item,
	output ouvs_pkg::out_t result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [ouvs_pkg::VALUE_W-1:0]  cells_q [CAPACITY];
	logic [CW-1:0]                 count_q;
	logic [CAPACITY-1:0]           match_s1;
	logic [ouvs_pkg::ACTION_W-1:0] action_s1;
	logic [ouvs_pkg::VALUE_W-1:0]  value_s1;
	ouvs_pkg::out_t                result_q;

	logic [CAPACITY-1:0] match;
	logic                present;
	logic [IW-1:0]       slot;
	logic                is_add;
	logic                is_del;
	logic                add_en;
	logic                del_en;
	logic                full;
	logic [CW-1:0]       count_nxt;
	logic [IW+ouvs_pkg::POS_W-1:0]   pos_ext;
	logic [CW+ouvs_pkg::COUNT_W-1:0] cnt_ext;

	// compare the incoming value against every held cell
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (cells_q[i] == $unsigned(item.value)) && (CW'(i) < count_q);
		end
	end

	// capture item and match vector at accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			match_s1  <= match;
			action_s1 <= item.action;
			value_s1  <= $unsigned(item.value);
		end
	end

	// locate first match and decide the update
	always_comb begin
		slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match_s1[i]) slot = IW'(i);
		end
		present   = |match_s1;
		is_add    = (action_s1 == ouvs_pkg::ACT_ADD);
		is_del    = (action_s1 == ouvs_pkg::ACT_DEL);
		full      = (count_q == CW'(CAPACITY));
		add_en    = cmd.update && is_add && !present && !full;
		del_en    = cmd.update && is_del && present;
		count_nxt = count_q;
		if (add_en) count_nxt = count_q + 1'b1;
		else if (del_en) count_nxt = count_q - 1'b1;
		pos_ext   = {{ouvs_pkg::POS_W{1'b0}}, (present ? slot : IW'(0))};
		cnt_ext   = {{ouvs_pkg::COUNT_W{1'b0}}, count_nxt};
	end

	// append at the tail or shift later cells down one place
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g < CAPACITY - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (add_en && (CW'(g) == count_q)) cells_q[g] <= value_s1;
				else if (del_en && (IW'(g) >= slot)) cells_q[g] <= cells_q[g+1];
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (add_en && (CW'(g) == count_q)) cells_q[g] <= value_s1;
			end
		end
	end

	// hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// register the result
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.was_present <= present;
			result_q.position    <= pos_ext[ouvs_pkg::POS_W-1:0];
			result_q.count       <= cnt_ext[ouvs_pkg::COUNT_W-1:0];
			result_q.overflow    <= is_add && !present && full;
		end
	end

	assign result = result_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> count_q == $past(count_q))
		else $error("fill count moved outside update");
	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		del_en |=> count_q == $past(count_q) - 1'b1)
		else $error("delete did not drop the fill count");
`endif

endmodule

/* sv/ordered_unique_value_set.sv */
// ----------------------------------------------------------------------------
// ordered_unique_value_set: set of distinct values kept in insertion order
// Add appends an absent value, delete removes a value and closes the gap,
// look up reports presence and position.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (action, value) with start high; the item is taken at a rising
//   edge where start is high and busy is low. The held cells are compared
//   with the value in the accept cycle, the store is updated in the next.
//   busy is high for that one update cycle, so no new item is taken while the
//   update is applied to the cell row.
//   The result (was_present, position, count, overflow) appears on result
//   with done high for exactly one cycle, the cycle after the update cycle,
//   and is taken at the rising edge that closes that cycle. It
//   reflects the presence and position before the action and the count
//   after it. The receiver cannot stall, so results must be taken as
//   they come; the next item may be accepted in the cycle done is high.
//   Reset (arst_n low) empties the set at once; cell contents are not
//   cleared and never read until written.
// ----------------------------------------------------------------------------
module ordered_unique_value_set #(
	parameter int CAPACITY = ouvs_pkg::DEF_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ouvs_pkg::in_t  item,
	output logic           done,
	output ouvs_pkg::out_t result
);

	ouvs_pkg::cmd_t cmd;

	ouvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ouvs_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

/* dv/ordered_unique_value_set_tb.sv */
// ----------------------------------------------------------------------------
// ordered_unique_value_set_tb: self-checking bench for the ordered value set
// Drives add, delete and look up items through the start/busy handshake,
// mirrors the held values in a local shadow set and compares every done
// result field by field. Directed items hit the value extremes, duplicates,
// absent deletes, the unused action code and a full store; random phases
// then build up and drain the set with values drawn mostly from a small pool.
// ----------------------------------------------------------------------------
module ordered_unique_value_set_tb;

	localparam int VALUE_W      = ouvs_pkg::VALUE_W;
	localparam int ACTION_W     = ouvs_pkg::ACTION_W;
	localparam int POS_W        = ouvs_pkg::POS_W;
	localparam int COUNT_W      = ouvs_pkg::COUNT_W;
	localparam int SET_CAPACITY = ouvs_pkg::DEF_CAPACITY;
	localparam int POOL_SIZE    = 24;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;

	// the spare action code is handled as a look up
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_NEG = -32'sd1;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	ouvs_pkg::in_t   item;
	logic            done;
	ouvs_pkg::out_t  result;

	// shadow of the held values, index 0 oldest
	logic signed [VALUE_W-1:0] shadow_vals [SET_CAPACITY];
	int                        shadow_count;
	ouvs_pkg::out_t            pending_results [$];

	logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
	bit                        no_idle;

	int unsigned mismatches;
	int unsigned items_taken;
	int unsigned results_seen;
	int unsigned hits_seen;
	int unsigned overflows_seen;
	int unsigned full_seen;
	int unsigned idle_cycles;

	ordered_unique_value_set #(
		.CAPACITY(SET_CAPACITY)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// apply one action to the shadow set and return the result it causes
	function automatic ouvs_pkg::out_t apply_set_action(ouvs_pkg::in_t it);
		ouvs_pkg::out_t r;
		int             slot;
		bit             found;
		slot  = shadow_count;
		found = 1'b0;
		for (int i = 0; i < shadow_count; i++) begin
			if (!found && shadow_vals[i] === it.value) begin
				slot  = i;
				found = 1'b1;
			end
		end
		r = '0;
		r.was_present = found;
		r.position    = found ? slot[POS_W-1:0] : '0;
		case (it.action)
			ouvs_pkg::ACT_ADD: begin
				if (!found) begin
					if (shadow_count < SET_CAPACITY) begin
						shadow_vals[shadow_count] = it.value;
						shadow_count++;
					end else begin
						r.overflow = 1'b1;
					end
				end
			end
			ouvs_pkg::ACT_DEL: begin
				if (found) begin
					for (int i = slot; i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i + 1];
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int exp_v, int got_v);
		$display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
		mismatches++;
	endtask

	// compare one result with the oldest pending expectation
	task automatic check_result(ouvs_pkg::out_t got);
		ouvs_pkg::out_t exp_r;
		if (pending_results.size() == 0) begin
			report_mismatch("result with no pending item", 0, 1);
		end else begin
			exp_r = pending_results.pop_front();
			if (got.was_present !== exp_r.was_present)
				report_mismatch("was_present", exp_r.was_present, got.was_present);
			if (got.position !== exp_r.position)
				report_mismatch("position", exp_r.position, got.position);
			if (got.count !== exp_r.count)
				report_mismatch("count", exp_r.count, got.count);
			if (got.overflow !== exp_r.overflow)
				report_mismatch("overflow", exp_r.overflow, got.overflow);
			if (got.was_present === 1'b1) hits_seen++;
			if (got.overflow === 1'b1) overflows_seen++;
			if (got.count === COUNT_W'(SET_CAPACITY)) full_seen++;
		end
	endtask

	// check results, predict accepted items, watch for a stalled run
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				check_result(result);
				results_seen++;
			end
			if (start && !busy) begin
				pending_results.push_back(apply_set_action(item));
				items_taken++;
			end
			if ((done === 1'b1) || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TIMEOUT: nothing moved for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones, none in burst phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// offer one item and hold it until the block takes it
	task automatic send_item(logic [ACTION_W-1:0] act,
		logic signed [VALUE_W-1:0] val);
		int            gap;
		ouvs_pkg::in_t it;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			item  <= ouvs_pkg::in_t'({ACTION_W'($urandom), 32'($urandom)});
			repeat (gap) @(posedge clk);
		end
		it.action = act;
		it.value  = val;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// extremes of the value range, duplicates, absent deletes, spare code
	task automatic test_extremes();
		send_item(ouvs_pkg::ACT_FIND, 32'sd0);
		send_item(ouvs_pkg::ACT_DEL, 32'sd0);
		send_item(ouvs_pkg::ACT_ADD, VAL_MIN);
		send_item(ouvs_pkg::ACT_ADD, VAL_MAX);
		send_item(ouvs_pkg::ACT_ADD, 32'sd0);
		send_item(ouvs_pkg::ACT_ADD, VAL_NEG);
		send_item(ouvs_pkg::ACT_ADD, VAL_MIN);
		send_item(ouvs_pkg::ACT_FIND, VAL_MAX);
		send_item(ACT_SPARE, 32'sd0);
		send_item(ACT_SPARE, 32'sd1);
		send_item(ouvs_pkg::ACT_FIND, 32'sd1);
		send_item(ouvs_pkg::ACT_DEL, 32'sd5);
		send_item(ouvs_pkg::ACT_DEL, VAL_MAX);
		send_item(ouvs_pkg::ACT_FIND, VAL_NEG);
		send_item(ouvs_pkg::ACT_DEL, VAL_MIN);
		send_item(ouvs_pkg::ACT_DEL, VAL_NEG);
		send_item(ouvs_pkg::ACT_FIND, 32'sd0);
		send_item(ouvs_pkg::ACT_DEL, 32'sd0);
	endtask

	// fill the store, overflow it, then free slots at both ends
	task automatic test_full_store();
		logic signed [VALUE_W-1:0] base;
		base = $urandom;
		for (int i = 0; i <= SET_CAPACITY; i++)
			send_item(ouvs_pkg::ACT_ADD, base + i);
		send_item(ouvs_pkg::ACT_ADD, base);
		send_item(ouvs_pkg::ACT_FIND, base + SET_CAPACITY - 1);
		send_item(ouvs_pkg::ACT_DEL, base);
		send_item(ouvs_pkg::ACT_DEL, base + SET_CAPACITY - 1);
		send_item(ouvs_pkg::ACT_ADD, VAL_MAX);
		send_item(ouvs_pkg::ACT_FIND, VAL_MAX);
	endtask

	// pool of extremes, random values and one-bit neighbors
	task automatic refill_pool();
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = 32'sd0;
		value_pool[3] = VAL_NEG;
		for (int i = 4; i < POOL_SIZE; i++) begin
			if ($urandom_range(0, 2) == 0)
				value_pool[i] = value_pool[i - 1] ^ (32'sd1 << $urandom_range(0, 31));
			else
				value_pool[i] = $urandom;
		end
	endtask

	// random phases that grow, churn and drain the set
	task automatic test_random_traffic(int phases, int per_phase);
		int                        add_bias;
		int                        r;
		logic [ACTION_W-1:0]       act;
		logic signed [VALUE_W-1:0] val;
		for (int p = 0; p < phases; p++) begin
			if (p % 3 == 0) refill_pool();
			case ($urandom_range(0, 2))
				0:       add_bias = 80;
				1:       add_bias = 45;
				default: add_bias = 15;
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < per_phase; n++) begin
				r = $urandom_range(0, 99);
				if (r < add_bias)
					act = ouvs_pkg::ACT_ADD;
				else if (r >= 97)
					act = ACT_SPARE;
				else if ((r - add_bias) % 2 == 0)
					act = ouvs_pkg::ACT_DEL;
				else
					act = ouvs_pkg::ACT_FIND;
				if ($urandom_range(0, 9) == 0)
					val = $urandom;
				else
					val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
				send_item(act, val);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		item           = '0;
		no_idle        = 1'b0;
		shadow_count   = 0;
		mismatches     = 0;
		items_taken    = 0;
		results_seen   = 0;
		hits_seen      = 0;
		overflows_seen = 0;
		full_seen      = 0;
		idle_cycles    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_full_store();
		test_random_traffic(12, 100);

		// drain outstanding results
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d results: %0d hits, %0d overflows, %0d at full",
			items_taken, results_seen, hits_seen, overflows_seen, full_seen);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
